>>> sv/tcsb_pkg.sv
// Shared types and constants for the text console screen buffer.
`timescale 1ns / 1ps

package tcsb_pkg;

	// default geometry
	localparam int COLUMNS_DEF = 16;
	localparam int ROWS_DEF    = 4;

	// character codes
	localparam int         CHAR_W     = 8;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_BLOCK = 8'h7f;

	// operation codes carried on the input tuser
	typedef enum logic [2:0] {
		OP_PUT     = 3'd0,
		OP_NEWLINE = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_MOVE    = 3'd3,
		OP_REFRESH = 3'd4
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_FILL,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_RESP
	} state_t;

endpackage

>>> sv/tcsb_ram.sv
// Character store: one write port, one registered read port.
`timescale 1ns / 1ps

module tcsb_ram #(
	parameter int DEPTH = tcsb_pkg::COLUMNS_DEF * tcsb_pkg::ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tcsb_pkg::CHAR_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [tcsb_pkg::CHAR_W-1:0] rdata
);

	logic [tcsb_pkg::CHAR_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/text_console_screen_buffer.sv
// Top level of the text console screen buffer: sequencer, cursor, dirty marks.
`timescale 1ns / 1ps
//
// Character console engine holding a COLUMNS x ROWS character store.
// Input stream (s_axis): one operation per item, opcode on tuser.
// Output stream (m_axis): one result per item, or COLUMNS results for a
// refresh that emits a row; tlast marks the final result of an item.
// cursor_shown is written through cfg_we / cfg_wdata; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
// Steps per item after accept: move, put without scroll, refresh with nothing
// to send and unknown opcodes go straight to the result; a newline without
// scroll blanks its new row one cell a cycle; a scroll (put or newline) copies
// the rows below the top up by one row, the single write port moving one cell a
// cycle, then blanks the bottom row; clear blanks every cell; a refresh that
// emits reads, then loads, each character of the row in turn.
// The block takes one item at a time; s_axis_tready is high only when idle.
// After reset the store is filled with spaces while s_axis_tready is low.
// A stalled receiver holds the output register and the sequencer waits on it;
// nothing is dropped.

module text_console_screen_buffer #(
	parameter int COLUMNS = tcsb_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcsb_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg: cursor_shown
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] char_code, [15:8] target_col, [23:16] target_row, [24] blink_phase
	input  logic [31:0] s_axis_tdata,
	// [2:0] opcode
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] char_out, [13:8] out_col, [16:14] out_row, [22:17] cursor_col,
	// [25:23] cursor_row, [26] scrolled
	output logic [31:0] m_axis_tdata,
	// [0] row_sent
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
	localparam logic [AW-1:0] COL_LASTA = AW'(COLUMNS - 1);
	localparam logic [AW-1:0] BOT_BASE  = AW'((ROWS - 1) * COLUMNS);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [7:0]    COLS_8    = 8'(COLUMNS);
	localparam logic [7:0]    ROWS_8    = 8'(ROWS);
	localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);

	tcsb_pkg::state_t state_q, state_d;

	// latched item
	tcsb_pkg::op_t op_q;
	logic [7:0]    ch_q;
	logic [7:0]    tc_q;
	logic [7:0]    tr_q;
	logic          blink_q;

	logic          shown_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [ROWS-1:0] dirty_q;
	logic          scr_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] fill_last_q;

	// scroll copy pipeline
	logic          pend_s1;
	logic [AW-1:0] waddr_s1;

	// store ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// output register
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_user_q;
	logic        out_last_q;
	logic        out_load;
	logic [31:0] out_data_d;
	logic        out_user_d;
	logic        out_last_d;

	logic          accept;
	logic          out_free;
	logic [RW-1:0] trr;
	logic          tr_ok;
	logic          show_row;
	logic [AW-1:0] put_addr;
	logic          copy_issue;
	logic [CW-1:0] emit_col;
	logic          emit_last;
	logic [7:0]    emit_char;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign trr        = tr_q[RW-1:0];
	assign tr_ok      = tr_q < ROWS_8;
	assign show_row   = tr_ok && (dirty_q[trr] || (shown_q && trr == cur_row_q));
	assign put_addr   = AW'(cur_row_q) * COLS_A + AW'(cur_col_q);
	assign copy_issue = cnt_q != COPY_END;
	assign emit_col   = cnt_q[CW-1:0];
	assign emit_last  = emit_col == COL_LAST;

	// displayed character: control codes as space, blinking cursor cell
	always_comb begin
		emit_char = (ram_rdata < tcsb_pkg::CHAR_SPACE) ? tcsb_pkg::CHAR_SPACE : ram_rdata;
		if (emit_col == cur_col_q && trr == cur_row_q && shown_q && blink_q) begin
			emit_char = tcsb_pkg::CHAR_BLOCK;
		end
	end

	tcsb_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcsb_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, store port and output load
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = base_q + cnt_q;
		ram_wdata  = tcsb_pkg::CHAR_SPACE;
		ram_re     = 1'b0;
		ram_raddr  = base_q + cnt_q;
		out_load   = 1'b0;
		out_data_d = '0;
		out_user_d = 1'b0;
		out_last_d = 1'b1;
		s_axis_tready = 1'b0;
		case (state_q)
			tcsb_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				if (cnt_q == CELL_LAST) begin
					state_d = tcsb_pkg::ST_IDLE;
				end
			end
			tcsb_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (accept) begin
					state_d = tcsb_pkg::ST_EXEC;
				end
			end
			tcsb_pkg::ST_EXEC: begin
				state_d = tcsb_pkg::ST_RESP;
				case (op_q)
					tcsb_pkg::OP_PUT: begin
						ram_we    = 1'b1;
						ram_waddr = put_addr;
						ram_wdata = ch_q;
						if (cur_col_q == COL_LAST && cur_row_q == ROW_LAST) begin
							state_d = tcsb_pkg::ST_SCROLL;
						end
					end
					tcsb_pkg::OP_NEWLINE: begin
						state_d = (cur_row_q == ROW_LAST) ? tcsb_pkg::ST_SCROLL
							: tcsb_pkg::ST_FILL;
					end
					tcsb_pkg::OP_CLEAR: begin
						state_d = tcsb_pkg::ST_FILL;
					end
					tcsb_pkg::OP_REFRESH: begin
						if (show_row) begin
							state_d = tcsb_pkg::ST_EMIT_RD;
						end
					end
					default: begin
						state_d = tcsb_pkg::ST_RESP;
					end
				endcase
			end
			tcsb_pkg::ST_SCROLL: begin
				// read a row below, write the cell read in the previous cycle
				ram_we    = pend_s1;
				ram_waddr = waddr_s1;
				ram_wdata = ram_rdata;
				ram_re    = copy_issue;
				ram_raddr = cnt_q + COLS_A;
				if (!copy_issue) begin
					state_d = tcsb_pkg::ST_FILL;
				end
			end
			tcsb_pkg::ST_FILL: begin
				ram_we = 1'b1;
				if (cnt_q == fill_last_q) begin
					state_d = tcsb_pkg::ST_RESP;
				end
			end
			tcsb_pkg::ST_EMIT_RD: begin
				ram_re  = 1'b1;
				state_d = tcsb_pkg::ST_EMIT_WR;
			end
			tcsb_pkg::ST_EMIT_WR: begin
				out_data_d = {5'd0, scr_q, 3'(cur_row_q), 6'(cur_col_q), 3'(trr),
					6'(emit_col), emit_char};
				out_user_d = 1'b1;
				out_last_d = emit_last;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = emit_last ? tcsb_pkg::ST_IDLE : tcsb_pkg::ST_EMIT_RD;
				end
			end
			tcsb_pkg::ST_RESP: begin
				out_data_d = {5'd0, scr_q, 3'(cur_row_q), 6'(cur_col_q), 17'd0};
				if (out_free) begin
					out_load = 1'b1;
					state_d  = tcsb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcsb_pkg::ST_IDLE;
			end
		endcase
	end

	// item latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= tcsb_pkg::op_t'(s_axis_tuser);
			ch_q    <= s_axis_tdata[7:0];
			tc_q    <= s_axis_tdata[15:8];
			tr_q    <= s_axis_tdata[23:16];
			blink_q <= s_axis_tdata[24];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= 1'b0;
		end else if (cfg_we) begin
			shown_q <= cfg_wdata;
		end
	end

	// cursor, dirty marks, sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			dirty_q     <= '1;
			scr_q       <= 1'b0;
			cnt_q       <= '0;
			base_q      <= '0;
			fill_last_q <= '0;
		end else begin
			case (state_q)
				tcsb_pkg::ST_INIT: begin
					cnt_q <= (cnt_q == CELL_LAST) ? '0 : cnt_q + 1'b1;
				end
				tcsb_pkg::ST_IDLE: begin
					if (accept) begin
						scr_q <= 1'b0;
						cnt_q <= '0;
					end
				end
				tcsb_pkg::ST_EXEC: begin
					case (op_q)
						tcsb_pkg::OP_PUT: begin
							if (cur_col_q == COL_LAST && cur_row_q == ROW_LAST) begin
								// last cell filled: the scroll marks every row
								cur_col_q <= '0;
								scr_q     <= 1'b1;
								dirty_q   <= '1;
							end else begin
								dirty_q[cur_row_q] <= 1'b1;
								if (cur_col_q == COL_LAST) begin
									cur_col_q <= '0;
									cur_row_q <= cur_row_q + 1'b1;
								end else begin
									cur_col_q <= cur_col_q + 1'b1;
								end
							end
						end
						tcsb_pkg::OP_NEWLINE: begin
							cur_col_q <= '0;
							if (cur_row_q == ROW_LAST) begin
								scr_q   <= 1'b1;
								dirty_q <= '1;
							end else begin
								cur_row_q <= cur_row_q + 1'b1;
								dirty_q[cur_row_q + 1'b1] <= 1'b1;
								base_q      <= AW'(cur_row_q + 1'b1) * COLS_A;
								fill_last_q <= COL_LASTA;
							end
						end
						tcsb_pkg::OP_CLEAR: begin
							dirty_q     <= '1;
							cur_col_q   <= '0;
							cur_row_q   <= '0;
							base_q      <= '0;
							fill_last_q <= CELL_LAST;
						end
						tcsb_pkg::OP_MOVE: begin
							cur_col_q <= (tc_q >= COLS_8) ? COL_LAST : tc_q[CW-1:0];
							cur_row_q <= (tr_q >= ROWS_8) ? ROW_LAST : tr_q[RW-1:0];
						end
						tcsb_pkg::OP_REFRESH: begin
							if (show_row) begin
								dirty_q[trr] <= 1'b0;
								base_q       <= AW'(trr) * COLS_A;
							end
						end
						default: begin
							cnt_q <= '0;
						end
					endcase
				end
				tcsb_pkg::ST_SCROLL: begin
					if (copy_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q       <= '0;
						base_q      <= BOT_BASE;
						fill_last_q <= COL_LASTA;
					end
				end
				tcsb_pkg::ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
				end
				tcsb_pkg::ST_EMIT_WR: begin
					if (out_load) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// scroll copy stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == tcsb_pkg::ST_SCROLL) && copy_issue;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= cnt_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_user_q <= out_user_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("output register overwritten");

	// the cursor row stays on screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_row_q} < ROWS_W)
		else $error("cursor row out of range");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("item accepted while busy");

	// a copy write only follows a copy read
	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q == tcsb_pkg::ST_SCROLL))
		else $error("copy write without read");
`endif

endmodule
